// File: design/fbs_pkg.sv
// Package for the frame builder: byte kind codes, function codes, register
// indexes and the descriptor type passed between the state and emit stages.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fbs_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [KIND_W-1:0] KIND_HEADER  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TYPE    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LENGTH  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SUM     = 3'd4;

  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_PAYLOAD = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 1'd1;

  // Byte positions within the beats of one item.
  localparam logic [IDX_W-1:0] POS_HEADER_FIRST  = 3'd0;
  localparam logic [IDX_W-1:0] POS_HEADER_SECOND = 3'd1;
  localparam logic [IDX_W-1:0] POS_TYPE          = 3'd2;
  localparam logic [IDX_W-1:0] POS_LEN_HIGH      = 3'd3;
  localparam logic [IDX_W-1:0] POS_LEN_LOW       = 3'd4;
  localparam logic [IDX_W-1:0] POS_START_SUM     = 3'd5;
  localparam logic [IDX_W-1:0] POS_PAYLOAD       = 3'd0;
  localparam logic [IDX_W-1:0] POS_PAYLOAD_SUM   = 3'd1;

  // Everything needed to emit the bytes of one accepted item.
  typedef struct packed {
    logic                is_start;
    logic [BYTE_W-1:0]   header_first;
    logic [BYTE_W-1:0]   header_second;
    logic [BYTE_W-1:0]   data_type;
    logic [LEN_W-1:0]    frame_length;
    logic [BYTE_W-1:0]   payload_byte;
    logic [BYTE_W-1:0]   sum_byte;
    logic                data_end;
    logic [IDX_W-1:0]    last_idx;
  } fbs_desc_t;

endpackage
`default_nettype wire

// File: design/fbs_item_if.sv
// Input item channel of the frame builder: valid/ready plus item fields.
// Depends on fbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface fbs_item_if
  import fbs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              func;
  logic [BYTE_W-1:0] data_type;
  logic [LEN_W-1:0]  frame_length;
  logic              sum_on;
  logic [BYTE_W-1:0] payload_byte;

  modport source (output valid, func, data_type, frame_length, sum_on, payload_byte,
                  input ready);
  modport sink (input valid, func, data_type, frame_length, sum_on, payload_byte,
                output ready);
endinterface
`default_nettype wire

// File: design/fbs_result_if.sv
// Result byte channel of the frame builder: valid/ready plus byte fields.
// Depends on fbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface fbs_result_if
  import fbs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic [KIND_W-1:0] byte_kind;
  logic              frame_end;

  modport source (output valid, out_byte, byte_kind, frame_end, input ready);
  modport sink (input valid, out_byte, byte_kind, frame_end, output ready);
endinterface
`default_nettype wire

// File: design/frame_builder_with_sum.sv
// Frame builder with additive checksum: top level.
// Depends on fbs_pkg, fbs_item_if, fbs_result_if, fbs_state and fbs_emit.
//
// Usage. Items arrive on the item channel. A start item (func = 0) yields
// the frame head: the two header bytes held in the configuration registers,
// the type byte and the length as high then low byte, and for an empty frame
// with the checksum flag also the checksum byte. A payload item (func = 1)
// yields its data byte if a frame is open, followed by the checksum byte when
// it closes a frame that asked for one. Every frame byte leaves as one beat
// of the result channel, and the beat that closes a frame carries frame_end.
// The first beat of an accepted item passes the descriptor register and then
// the output register on its way to the result channel.
// Throughput: the result channel carries one beat a cycle while the receiver
// is ready; a payload item yields one beat, or two when the checksum follows,
// and a start item five or six beats. The next item is accepted in the cycle
// its predecessor's last beat enters the output register, so back-to-back
// payload items stream at one beat per cycle when the receiver does not stall.
// Reset clears the frame state, the header registers and both valid flags;
// no clearing pass is needed. When the receiver stalls, the output register
// holds its beat and the descriptor register holds the item in progress, and
// the item channel drops ready until the backlog moves.
// The header registers are written through cfg_we, cfg_index and cfg_data, by
// the user only while the block is idle; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module frame_builder_with_sum
  import fbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  fbs_item_if.sink                   item,
  fbs_result_if.source               result
);

  // A beat on the item channel.
  logic      take;
  fbs_desc_t desc;
  logic      desc_ok;
  logic      in_ready;

  assign take       = item.valid && in_ready;
  assign item.ready = in_ready;

  // Frame state advances when an item is taken; it also works out the
  // checksum byte up front, so the sequencer only has to select.
  fbs_state u_state (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .take         (take),
    .func         (item.func),
    .data_type    (item.data_type),
    .frame_length (item.frame_length),
    .sum_on       (item.sum_on),
    .payload_byte (item.payload_byte),
    .desc         (desc),
    .desc_ok      (desc_ok)
  );

  // Steps through the bytes of the held item into the output register.
  fbs_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .desc_in   (desc),
    .desc_ok   (desc_ok),
    .in_ready  (in_ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_byte  (result.out_byte),
    .byte_kind (result.byte_kind),
    .frame_end (result.frame_end)
  );

  // Once a start item is taken, result valid is high by the time the item could
  // pass the descriptor and output registers, whether or not the receiver is stalled.
  a_start_reaches_output: assert property (@(posedge clk) disable iff (rst)
    take && (item.func == FUNC_START) |-> ##2 result.valid)
    else $error("start item produced no result beat");

  // The item channel is only held off while a result beat is pending.
  a_stall_has_backlog: assert property (@(posedge clk) disable iff (rst)
    !item.ready |=> result.valid)
    else $error("item channel stalled with no result pending");

  // A checksum byte always closes its frame.
  a_sum_closes_frame: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.byte_kind == KIND_SUM) |-> result.frame_end)
    else $error("checksum byte without frame end");

endmodule
`default_nettype wire

// File: design/fbs_state.sv
// Frame state and header registers; builds the emit descriptor of an item.
// Depends on fbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fbs_state
  import fbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  take,
  input  wire logic                  func,
  input  wire logic [BYTE_W-1:0]     data_type,
  input  wire logic [LEN_W-1:0]      frame_length,
  input  wire logic                  sum_on,
  input  wire logic [BYTE_W-1:0]     payload_byte,
  output fbs_desc_t                  desc,
  output logic                       desc_ok
);

  logic [BYTE_W-1:0] header_first;
  logic [BYTE_W-1:0] header_second;
  logic              frame_open;
  logic [LEN_W-1:0]  bytes_left;
  logic [BYTE_W-1:0] running_sum;
  logic              sum_wanted;

  logic              is_start;
  logic              empty;
  logic [LEN_W-1:0]  left_dec;
  logic              last;
  logic [BYTE_W-1:0] start_sum;
  logic [BYTE_W-1:0] pay_sum;

  always_comb begin
    is_start  = (func == FUNC_START);
    empty     = (frame_length == '0);
    left_dec  = bytes_left - LEN_W'(1);
    last      = (left_dec == '0);
    start_sum = header_first + header_second + data_type
              + frame_length[15:8] + frame_length[7:0];
    pay_sum   = running_sum + payload_byte;

    desc.is_start      = is_start;
    desc.header_first  = header_first;
    desc.header_second = header_second;
    desc.data_type     = data_type;
    desc.frame_length  = frame_length;
    desc.payload_byte  = payload_byte;
    if (is_start) begin
      desc.sum_byte = start_sum;
      desc.data_end = empty && !sum_on;
      desc.last_idx = (empty && sum_on) ? POS_START_SUM : POS_LEN_LOW;
    end else begin
      desc.sum_byte = pay_sum;
      desc.data_end = last && !sum_wanted;
      desc.last_idx = (last && sum_wanted) ? POS_PAYLOAD_SUM : POS_PAYLOAD;
    end
    // A payload beat with no open frame is dropped.
    desc_ok = is_start || frame_open;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= '0;
      header_second <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADER_FIRST:  header_first  <= cfg_data;
        REG_HEADER_SECOND: header_second <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open  <= 1'b0;
      bytes_left  <= '0;
      running_sum <= '0;
      sum_wanted  <= 1'b0;
    end else if (take) begin
      if (is_start) begin
        frame_open  <= !empty;
        bytes_left  <= frame_length;
        running_sum <= start_sum;
        sum_wanted  <= !empty && sum_on;
      end else if (frame_open) begin
        bytes_left  <= left_dec;
        running_sum <= pay_sum;
        if (last) begin
          frame_open <= 1'b0;
          sum_wanted <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: design/fbs_emit.sv
// Descriptor register, byte sequencer and output register of the builder.
// Depends on fbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fbs_emit
  import fbs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire fbs_desc_t         desc_in,
  input  wire logic              desc_ok,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BYTE_W-1:0]      out_byte,
  output logic [KIND_W-1:0]      byte_kind,
  output logic                   frame_end
);

  fbs_desc_t         desc;
  logic              desc_valid;
  logic [IDX_W-1:0]  idx;

  logic              load_out;
  logic              at_last;
  logic [BYTE_W-1:0] sel_byte;
  logic [KIND_W-1:0] sel_kind;
  logic              sel_end;

  always_comb begin
    load_out = desc_valid && (!out_valid || out_ready);
    at_last  = (idx == desc.last_idx);
    in_ready = !desc_valid || (load_out && at_last);
  end

  always_comb begin
    sel_byte = desc.sum_byte;
    sel_kind = KIND_SUM;
    sel_end  = 1'b1;
    if (desc.is_start) begin
      case (idx)
        POS_HEADER_FIRST: begin
          sel_byte = desc.header_first;
          sel_kind = KIND_HEADER;
          sel_end  = 1'b0;
        end
        POS_HEADER_SECOND: begin
          sel_byte = desc.header_second;
          sel_kind = KIND_HEADER;
          sel_end  = 1'b0;
        end
        POS_TYPE: begin
          sel_byte = desc.data_type;
          sel_kind = KIND_TYPE;
          sel_end  = 1'b0;
        end
        POS_LEN_HIGH: begin
          sel_byte = desc.frame_length[15:8];
          sel_kind = KIND_LENGTH;
          sel_end  = 1'b0;
        end
        POS_LEN_LOW: begin
          sel_byte = desc.frame_length[7:0];
          sel_kind = KIND_LENGTH;
          sel_end  = desc.data_end;
        end
        default: ;
      endcase
    end else if (idx == POS_PAYLOAD) begin
      sel_byte = desc.payload_byte;
      sel_kind = KIND_PAYLOAD;
      sel_end  = desc.data_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
      idx        <= '0;
    end else if (take) begin
      desc_valid <= desc_ok;
      idx        <= '0;
    end else if (load_out) begin
      if (at_last) begin
        desc_valid <= 1'b0;
      end
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      desc <= desc_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_byte  <= sel_byte;
      byte_kind <= sel_kind;
      frame_end <= sel_end;
    end
  end

endmodule
`default_nettype wire

// File: tb/frame_builder_with_sum_tb.sv
// Testbench for frame_builder_with_sum: directed frames, then random frame traffic
// under varying idle and stall patterns, checked beat by beat against a predictor.
// Depends on fbs_pkg, fbs_item_if, fbs_result_if and the frame builder RTL.
`timescale 1ns / 1ps
module frame_builder_with_sum_tb;
  import fbs_pkg::*;

  // A generous ceiling on the run.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Cycles allowed for an item that yields no beat to clear the pipeline:
  // descriptor register plus output register, with some margin.
  localparam int unsigned SETTLE_CYCLES = 6;

  // One item as the sender presents it.
  typedef struct {
    logic              func;
    logic [BYTE_W-1:0] data_type;
    logic [LEN_W-1:0]  frame_length;
    logic              sum_on;
    logic [BYTE_W-1:0] payload_byte;
  } frame_item_t;

  // One frame byte as it should leave the result channel.
  typedef struct {
    logic [BYTE_W-1:0] out_byte;
    logic [KIND_W-1:0] byte_kind;
    logic              frame_end;
  } frame_byte_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fbs_item_if   item_ch ();
  fbs_result_if result_ch ();

  frame_builder_with_sum dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  // Our own copy of the block's registers and frame state.
  logic [BYTE_W-1:0] hdr_first_q;
  logic [BYTE_W-1:0] hdr_second_q;
  logic              open_q;
  logic [LEN_W-1:0]  left_q;
  logic [BYTE_W-1:0] sum_q;
  logic              want_sum_q;

  // Frame bytes predicted but not yet seen, oldest first.
  frame_byte_t expected_bytes[$];

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned useful_items;  // items that produced at least one beat
  int unsigned tx_gap_pct;    // chance per cycle that the sender idles
  int unsigned rx_stall_pct;  // chance per cycle that the receiver stalls

  // Clock with a 12 ns period.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Appends one expected byte and folds it into the running checksum, just as
  // the block sums every byte it emits ahead of the checksum.
  function automatic void queue_byte(input logic [BYTE_W-1:0] b,
                                     input logic [KIND_W-1:0] kind,
                                     input logic fend);
    frame_byte_t fb;
    fb.out_byte  = b;
    fb.byte_kind = kind;
    fb.frame_end = fend;
    expected_bytes.push_back(fb);
    sum_q = sum_q + b;
  endfunction

  // Works out the beats caused by one accepted item and updates the frame
  // state. Returns how many beats were predicted.
  function automatic int predict_frame_bytes(input frame_item_t it);
    logic empty;
    logic last;
    int   n;
    n = 0;
    if (it.func == FUNC_START) begin
      // A start always opens afresh: any frame still open is simply dropped.
      empty = (it.frame_length == '0);
      sum_q = '0;
      queue_byte(hdr_first_q, KIND_HEADER, 1'b0);
      queue_byte(hdr_second_q, KIND_HEADER, 1'b0);
      queue_byte(it.data_type, KIND_TYPE, 1'b0);
      queue_byte(it.frame_length[15:8], KIND_LENGTH, 1'b0);
      queue_byte(it.frame_length[7:0], KIND_LENGTH, empty && !it.sum_on);
      n = 5;
      if (empty) begin
        // An empty frame closes on its head, or on the checksum after it.
        if (it.sum_on) begin
          queue_byte(sum_q, KIND_SUM, 1'b1);
          n = 6;
        end
        open_q     = 1'b0;
        left_q     = '0;
        want_sum_q = 1'b0;
      end else begin
        open_q     = 1'b1;
        left_q     = it.frame_length;
        want_sum_q = it.sum_on;
      end
      return n;
    end
    // A payload byte with no open frame is discarded without trace.
    if (!open_q) begin
      return 0;
    end
    left_q = left_q - LEN_W'(1);
    last   = (left_q == '0);
    queue_byte(it.payload_byte, KIND_PAYLOAD, last && !want_sum_q);
    n = 1;
    if (last) begin
      if (want_sum_q) begin
        queue_byte(sum_q, KIND_SUM, 1'b1);
        n = 2;
      end
      open_q     = 1'b0;
      want_sum_q = 1'b0;
    end
    return n;
  endfunction

  // The receiver stalls at random, at a rate set per phase. Ready changes on
  // the falling edge only.
  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Every beat taken on a rising edge is compared with the oldest prediction.
  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected beat: out_byte %0h byte_kind %0d frame_end %0b",
               result_ch.out_byte, result_ch.byte_kind, result_ch.frame_end);
        error_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (result_ch.out_byte !== want.out_byte) begin
          $error("out_byte mismatch: expected %0h, actual %0h",
                 want.out_byte, result_ch.out_byte);
          error_count++;
        end
        if (result_ch.byte_kind !== want.byte_kind) begin
          $error("byte_kind mismatch: expected %0d, actual %0d",
                 want.byte_kind, result_ch.byte_kind);
          error_count++;
        end
        if (result_ch.frame_end !== want.frame_end) begin
          $error("frame_end mismatch: expected %0b, actual %0b",
                 want.frame_end, result_ch.frame_end);
          error_count++;
        end
      end
    end
  end

  // Presents one item from a falling edge, with random idle cycles first, and
  // returns on the falling edge after the beat has been taken. Valid is left
  // high so that a following item runs on without a gap.
  task automatic send_item(input frame_item_t it);
    while ($urandom_range(99) < tx_gap_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.func         <= it.func;
    item_ch.data_type    <= it.data_type;
    item_ch.frame_length <= it.frame_length;
    item_ch.sum_on       <= it.sum_on;
    item_ch.payload_byte <= it.payload_byte;
    do begin
      @(posedge clk);
    end while (!item_ch.ready);
    if (predict_frame_bytes(it) > 0) begin
      useful_items++;
    end
    @(negedge clk);
  endtask

  // A start beat; the unused payload field carries noise.
  task automatic send_start(input logic [BYTE_W-1:0] dtype, input logic [LEN_W-1:0] len,
                            input logic with_sum);
    frame_item_t it;
    it.func         = FUNC_START;
    it.data_type    = dtype;
    it.frame_length = len;
    it.sum_on       = with_sum;
    it.payload_byte = BYTE_W'($urandom_range(255));
    send_item(it);
  endtask

  // A payload beat; the fields used only on a start carry noise.
  task automatic send_payload(input logic [BYTE_W-1:0] pay);
    frame_item_t it;
    it.func         = FUNC_PAYLOAD;
    it.data_type    = BYTE_W'($urandom_range(255));
    it.frame_length = LEN_W'($urandom_range(65535));
    it.sum_on       = 1'($urandom_range(1));
    it.payload_byte = pay;
    send_item(it);
  endtask

  // Holds the sender off until every predicted beat has arrived, then lets
  // the pipeline settle in case the last items were dropped payloads.
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes one header register; only ever called with the block idle.
  task automatic write_header(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_HEADER_FIRST) begin
      hdr_first_q = val;
    end else begin
      hdr_second_q = val;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Empty frames with the header registers still at their reset value, plus
  // a payload byte arriving before any frame was ever opened.
  task automatic test_empty_frames();
    send_payload(8'hFF);
    send_start(8'h00, 16'h0000, 1'b0);
    send_start(8'hFF, 16'h0000, 1'b1);
    wait_idle();
  endtask

  // Short complete frames with and without the checksum, and a stray payload
  // byte once the frame has closed.
  task automatic test_short_frames();
    write_header(REG_HEADER_FIRST, 8'hFF);
    write_header(REG_HEADER_SECOND, 8'h00);
    send_start(8'hA5, 16'h0001, 1'b0);
    send_payload(8'hFF);
    send_start(8'h5A, 16'h0002, 1'b1);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_payload(8'h80);
    wait_idle();
  endtask

  // The widest lengths, with frames abandoned part way by a fresh start; the last
  // frame to complete has a checksum that wraps, and the final start gets no payload.
  task automatic test_abandoned_frames();
    write_header(REG_HEADER_FIRST, 8'h00);
    write_header(REG_HEADER_SECOND, 8'hFF);
    send_start(8'h3C, 16'hFFFF, 1'b1);
    send_payload(8'h01);
    send_payload(8'hFE);
    send_start(8'hC3, 16'h0100, 1'b0);
    send_payload(8'h55);
    send_start(8'hFF, 16'h0001, 1'b1);
    send_payload(8'hFF);
    send_start(8'h81, 16'h00FF, 1'b1);
    wait_idle();
  endtask

  // Random traffic: mostly whole frames with random content, some abandoned
  // part way, some stray payload bytes, and now and then a full pause.
  task automatic test_random_frames(input int unsigned n_items,
                                    input int unsigned gap_pct,
                                    input int unsigned stall_pct);
    int unsigned      target;
    int unsigned      pick;
    int unsigned      count;
    logic [LEN_W-1:0] len;
    tx_gap_pct   = gap_pct;
    rx_stall_pct = stall_pct;
    write_header(REG_HEADER_FIRST, CFG_DATA_W'($urandom_range(255)));
    write_header(REG_HEADER_SECOND, CFG_DATA_W'($urandom_range(255)));
    target = useful_items + n_items;
    while (useful_items < target) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_payload(BYTE_W'($urandom_range(255)));
      end else begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          len = LEN_W'($urandom_range(6));
        end else if (pick < 88) begin
          len = LEN_W'($urandom_range(24, 7));
        end else if (pick < 96) begin
          len = LEN_W'($urandom_range(64, 25));
        end else begin
          len = LEN_W'($urandom_range(65535));
        end
        send_start(BYTE_W'($urandom_range(255)), len, 1'($urandom_range(1)));
        // Most frames run to their end; the rest get at most six payload bytes and,
        // unless that reaches their end, are abandoned by whatever comes next.
        if (len <= 64 && $urandom_range(99) < 85) begin
          count = len;
        end else begin
          count = $urandom_range((len < 6) ? len : 6);
        end
        repeat (count) send_payload(BYTE_W'($urandom_range(255)));
      end
      if ($urandom_range(99) < 3) begin
        wait_idle();
      end
    end
    wait_idle();
  endtask

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = REG_HEADER_FIRST;
    cfg_data        = '0;
    item_ch.valid   = 1'b0;
    item_ch.func    = FUNC_START;
    item_ch.data_type    = '0;
    item_ch.frame_length = '0;
    item_ch.sum_on       = 1'b0;
    item_ch.payload_byte = '0;
    result_ch.ready = 1'b0;
    hdr_first_q     = '0;
    hdr_second_q    = '0;
    open_q          = 1'b0;
    left_q          = '0;
    sum_q           = '0;
    want_sum_q      = 1'b0;
    cycle_count     = 0;
    error_count     = 0;
    useful_items    = 0;
    tx_gap_pct      = 0;
    rx_stall_pct    = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_frames();
    test_short_frames();
    test_abandoned_frames();

    // Four idling patterns in turn, each with fresh header values.
    test_random_frames(100, 0, 0);
    test_random_frames(100, 57, 0);
    test_random_frames(100, 0, 57);
    test_random_frames(100, 30, 30);

    // A last short phase with both headers at their top value.
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    write_header(REG_HEADER_FIRST, 8'hFF);
    write_header(REG_HEADER_SECOND, 8'hFF);
    send_start(8'hFF, 16'h0003, 1'b1);
    repeat (3) send_payload(8'hFF);
    send_start(8'h00, 16'h0000, 1'b1);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      $error("%0d predicted beats never arrived", expected_bytes.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
design/fbs_pkg.sv
design/fbs_item_if.sv
design/fbs_result_if.sv
design/fbs_state.sv
design/fbs_emit.sv
design/frame_builder_with_sum.sv
tb/frame_builder_with_sum_tb.sv
